/* sv/utf8_decoder_with_position_core_macros.svh */
// assertion helpers shared by the decoder modules
`ifndef UTF8_DECODER_WITH_POSITION_CORE_MACROS_SVH
`define UTF8_DECODER_WITH_POSITION_CORE_MACROS_SVH

// condition must hold at every edge out of reset
`define U8DP_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define U8DP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/u8dp_pkg.sv */
`default_nettype none
package u8dp_pkg;

  localparam int COUNT_WIDTH = 32;
  // counters never pass 2^32-1, so they need no more than 32 bits
  localparam int CNT_W = (COUNT_WIDTH < 32) ? COUNT_WIDTH : 32;
  localparam int POS_W = 32;
  localparam int CP_W = 21;
  localparam int LEN_W = 3;

  localparam int FQ_DEPTH = 2;
  localparam int FQ_PTR_W = $clog2(FQ_DEPTH);
  localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1);
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  localparam logic [7:0] MASK_TOP1 = 8'b1000_0000;
  localparam logic [7:0] MASK_TOP2 = 8'b1100_0000;
  localparam logic [7:0] MASK_TOP3 = 8'b1110_0000;
  localparam logic [7:0] MASK_TOP4 = 8'b1111_0000;
  localparam logic [7:0] MASK_TOP5 = 8'b1111_1000;
  localparam logic [7:0] MASK_LOW6 = 8'b0011_1111;
  localparam logic [7:0] LF_CODE = 8'h0A;
  localparam logic [7:0] CR_CODE = 8'h0D;

  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [2:0] {
    CLS_ASCII,
    CLS_CONT,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_BAD
  } byte_cls_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_BAD_LEAD,
    ST_MISSING,
    ST_TRUNC
  } status_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       final_byte;
  } src_item_t;

  typedef struct packed {
    logic [CP_W-1:0]  code_point;
    status_t          status;
    logic [LEN_W-1:0] seq_length;
    logic [POS_W-1:0] line_number;
    logic [POS_W-1:0] column_number;
    logic [POS_W-1:0] point_index;
    logic [POS_W-1:0] byte_offset;
    logic             stream_end;
  } res_item_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       final_byte;
    byte_cls_t  cls;
  } cls_item_t;

  // slot 1 is only used together with slot 0
  typedef struct packed {
    logic      push0;
    logic      push1;
    res_item_t res0;
    res_item_t res1;
  } oq_push_t;

  function automatic cnt_t sat_inc(cnt_t v);
    return (&v) ? v : v + cnt_t'(1);
  endfunction

  function automatic res_item_t make_res(logic [CP_W-1:0] cp, status_t st,
                                         logic [LEN_W-1:0] len, cnt_t line, cnt_t col,
                                         cnt_t pt, cnt_t off);
    res_item_t r;
    r.code_point    = cp;
    r.status        = st;
    r.seq_length    = len;
    r.line_number   = POS_W'(line);
    r.column_number = POS_W'(col);
    r.point_index   = POS_W'(pt);
    r.byte_offset   = POS_W'(off);
    r.stream_end    = 1'b0;
    return r;
  endfunction

endpackage
`default_nettype wire

/* sv/u8dp_front.sv */
`default_nettype none
module u8dp_front
  import u8dp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      src_valid,
  output logic           src_stall,
  input  wire src_item_t src_data,
  output logic           item_valid,
  output cls_item_t      item,
  input  wire logic      item_take
);

  cls_item_t             q [FQ_DEPTH];
  logic [FQ_PTR_W-1:0]   wp;
  logic [FQ_PTR_W-1:0]   rp;
  logic [FQ_CNT_W-1:0]   cnt;
  logic                  push;
  cls_item_t             cls_in;

  always_comb begin
    cls_in.byte_value = src_data.byte_value;
    cls_in.final_byte = src_data.final_byte;
    priority if ((src_data.byte_value & MASK_TOP1) == 8'h00) cls_in.cls = CLS_ASCII;
    else if ((src_data.byte_value & MASK_TOP2) == MASK_TOP1) cls_in.cls = CLS_CONT;
    else if ((src_data.byte_value & MASK_TOP3) == MASK_TOP2) cls_in.cls = CLS_LEAD2;
    else if ((src_data.byte_value & MASK_TOP4) == MASK_TOP3) cls_in.cls = CLS_LEAD3;
    else if ((src_data.byte_value & MASK_TOP5) == MASK_TOP4) cls_in.cls = CLS_LEAD4;
    else cls_in.cls = CLS_BAD;
  end

  assign src_stall  = (cnt == FQ_CNT_W'(FQ_DEPTH));
  assign push       = src_valid && !src_stall;
  assign item_valid = (cnt != '0);
  assign item       = q[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= cls_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + FQ_PTR_W'(1);
      if (item_take) rp <= rp + FQ_PTR_W'(1);
      unique case ({push, item_take})
        2'b10:   cnt <= cnt + FQ_CNT_W'(1);
        2'b01:   cnt <= cnt - FQ_CNT_W'(1);
        default: cnt <= cnt;
      endcase
    end
  end

endmodule
`default_nettype wire

/* sv/u8dp_back.sv */
`default_nettype none
`include "utf8_decoder_with_position_core_macros.svh"
module u8dp_back
  import u8dp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      item_valid,
  input  wire cls_item_t item,
  output logic           item_take,
  input  wire logic      space_ok,
  output oq_push_t       push
);

  logic [1:0]       pend_cnt, pend_cnt_next;
  logic [CP_W-1:0]  acc, acc_next;
  logic [LEN_W-1:0] pend_len, pend_len_next;
  cnt_t             start_off, start_off_next;
  cnt_t             byte_cnt, byte_cnt_next;
  cnt_t             point_cnt, point_cnt_next;
  cnt_t             line_cnt, line_cnt_next;
  cnt_t             col_cnt, col_cnt_next;
  cnt_t             start_line, start_line_next;
  cnt_t             start_col, start_col_next;

  logic             lead;
  logic             a_valid, b_valid;
  res_item_t        res_a, res_b;
  logic [CP_W-1:0]  acc_cont;
  logic [1:0]       pc_dec;
  cnt_t             col_l;
  logic             fin;

  assign item_take = item_valid && space_ok;
  assign fin       = item.final_byte;
  assign acc_cont  = {acc[CP_W-7:0], item.byte_value[5:0] & MASK_LOW6[5:0]};
  assign pc_dec    = pend_cnt - 2'd1;

  always_comb begin
    pend_cnt_next   = pend_cnt;
    acc_next        = acc;
    pend_len_next   = pend_len;
    start_off_next  = start_off;
    byte_cnt_next   = byte_cnt;
    point_cnt_next  = point_cnt;
    line_cnt_next   = line_cnt;
    col_cnt_next    = col_cnt;
    start_line_next = start_line;
    start_col_next  = start_col;
    lead    = 1'b1;
    a_valid = 1'b0;
    b_valid = 1'b0;
    res_a   = '0;
    res_b   = '0;
    col_l   = col_cnt;

    // open sequence: continuation, truncation or abort
    if (pend_cnt != 2'd0) begin
      if (item.cls == CLS_CONT) begin
        lead          = 1'b0;
        acc_next      = acc_cont;
        byte_cnt_next = sat_inc(byte_cnt);
        pend_cnt_next = pc_dec;
        if (pc_dec == 2'd0) begin
          a_valid = 1'b1;
          res_a   = make_res(acc_cont, ST_OK, pend_len, start_line, start_col,
                             point_cnt, start_off);
          point_cnt_next = sat_inc(point_cnt);
          if (acc_cont == CP_W'(LF_CODE)) begin
            line_cnt_next = sat_inc(line_cnt);
            col_cnt_next  = cnt_t'(1);
          end else begin
            col_cnt_next = sat_inc(col_cnt);
          end
        end else if (fin) begin
          a_valid = 1'b1;
          res_a   = make_res('0, ST_TRUNC, pend_len - {1'b0, pc_dec}, start_line,
                             start_col, point_cnt, start_off);
          col_cnt_next  = sat_inc(col_cnt);
          pend_cnt_next = 2'd0;
        end
      end else begin
        a_valid = 1'b1;
        res_a   = make_res('0, ST_MISSING, pend_len - {1'b0, pend_cnt}, start_line,
                           start_col, point_cnt, start_off);
        col_cnt_next  = sat_inc(col_cnt);
        pend_cnt_next = 2'd0;
        col_l         = sat_inc(col_cnt);
      end
    end

    // lead byte, possibly the one that aborted a sequence
    if (lead) begin
      start_off_next  = byte_cnt;
      start_line_next = line_cnt;
      start_col_next  = col_l;
      byte_cnt_next   = sat_inc(byte_cnt);
      b_valid         = 1'b1;
      unique case (item.cls)
        CLS_ASCII: begin
          res_b = make_res(CP_W'(item.byte_value), ST_OK, LEN_W'(1), line_cnt, col_l,
                           point_cnt, byte_cnt);
          point_cnt_next = sat_inc(point_cnt);
          if (item.byte_value == LF_CODE) begin
            line_cnt_next = sat_inc(line_cnt);
            col_cnt_next  = cnt_t'(1);
          end else begin
            col_cnt_next = sat_inc(col_l);
          end
        end
        CLS_LEAD2, CLS_LEAD3, CLS_LEAD4: begin
          if (fin) begin
            res_b = make_res('0, ST_TRUNC, LEN_W'(1), line_cnt, col_l, point_cnt,
                             byte_cnt);
            col_cnt_next = sat_inc(col_l);
            acc_next     = '0;
          end else begin
            b_valid = 1'b0;
            unique case (item.cls)
              CLS_LEAD2: begin
                acc_next      = CP_W'(item.byte_value[4:0]);
                pend_len_next = LEN_W'(2);
                pend_cnt_next = 2'd1;
              end
              CLS_LEAD3: begin
                acc_next      = CP_W'(item.byte_value[3:0]);
                pend_len_next = LEN_W'(3);
                pend_cnt_next = 2'd2;
              end
              default: begin
                acc_next      = CP_W'(item.byte_value[2:0]);
                pend_len_next = LEN_W'(4);
                pend_cnt_next = 2'd3;
              end
            endcase
          end
        end
        default: begin
          // stray continuation or byte that cannot lead
          res_b = make_res('0, ST_BAD_LEAD, LEN_W'(1), line_cnt, col_l, point_cnt,
                           byte_cnt);
          col_cnt_next = sat_inc(col_l);
        end
      endcase
    end

    if (fin) begin
      pend_cnt_next   = 2'd0;
      acc_next        = '0;
      pend_len_next   = '0;
      start_off_next  = '0;
      byte_cnt_next   = '0;
      point_cnt_next  = '0;
      line_cnt_next   = cnt_t'(1);
      col_cnt_next    = cnt_t'(1);
      start_line_next = cnt_t'(1);
      start_col_next  = cnt_t'(1);
      if (b_valid) res_b.stream_end = 1'b1;
      else res_a.stream_end = 1'b1;
    end
  end

  always_comb begin
    push.push0 = item_take && (a_valid || b_valid);
    push.push1 = item_take && a_valid && b_valid;
    push.res0  = a_valid ? res_a : res_b;
    push.res1  = res_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_cnt   <= 2'd0;
      acc        <= '0;
      pend_len   <= '0;
      start_off  <= '0;
      byte_cnt   <= '0;
      point_cnt  <= '0;
      line_cnt   <= cnt_t'(1);
      col_cnt    <= cnt_t'(1);
      start_line <= cnt_t'(1);
      start_col  <= cnt_t'(1);
    end else if (item_take) begin
      pend_cnt   <= pend_cnt_next;
      acc        <= acc_next;
      pend_len   <= pend_len_next;
      start_off  <= start_off_next;
      byte_cnt   <= byte_cnt_next;
      point_cnt  <= point_cnt_next;
      line_cnt   <= line_cnt_next;
      col_cnt    <= col_cnt_next;
      start_line <= start_line_next;
      start_col  <= start_col_next;
    end
  end

  `U8DP_ASSERT_ALWAYS(a_pend_in_len, (pend_cnt == 2'd0) || ({1'b0, pend_cnt} < pend_len), "open sequence count not below its length")
  `U8DP_ASSERT_NEXT(a_fin_clears, item_take && item.final_byte, (pend_cnt == 2'd0) && (byte_cnt == '0), "state not cleared after last byte")

endmodule
`default_nettype wire

/* sv/u8dp_outq.sv */
`default_nettype none
`include "utf8_decoder_with_position_core_macros.svh"
module u8dp_outq
  import u8dp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire oq_push_t push,
  output logic          space_ok,
  output logic          res_valid,
  input  wire logic     res_stall,
  output res_item_t     res_data
);

  res_item_t           q [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wp;
  logic [OQ_PTR_W-1:0] rp;
  logic [OQ_CNT_W-1:0] cnt;
  logic                pop;
  logic [OQ_CNT_W-1:0] n_in;

  // room for the two results one byte can cause
  assign space_ok  = (cnt <= OQ_CNT_W'(OQ_DEPTH - 2));
  assign res_valid = (cnt != '0);
  assign res_data  = q[rp];
  assign pop       = res_valid && !res_stall;
  assign n_in      = OQ_CNT_W'(push.push0) + OQ_CNT_W'(push.push1);

  always_ff @(posedge clk) begin
    if (push.push0) q[wp] <= push.res0;
    if (push.push1) q[wp + OQ_PTR_W'(1)] <= push.res1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      wp  <= wp + OQ_PTR_W'(n_in);
      if (pop) rp <= rp + OQ_PTR_W'(1);
      cnt <= cnt + n_in - OQ_CNT_W'(pop);
    end
  end

  `U8DP_ASSERT_ALWAYS(a_no_overflow, cnt <= OQ_CNT_W'(OQ_DEPTH), "result queue overflow")
  `U8DP_ASSERT_ALWAYS(a_slot_order, !push.push1 || (push.push0 && space_ok), "second slot written without first or without room")

endmodule
`default_nettype wire

/* sv/utf8_decoder_with_position_core.sv */
// channel | direction | payload    | handshake
// src     | in        | src_item_t | src_valid / src_stall
// res     | out       | res_item_t | res_valid / res_stall
//
// one byte per clock while results drain; a byte is queued, then its result is queued
// aborting a sequence without opening one yields two results, one per unstalled clock
// rate is set by the back end, which updates its state for each byte it takes
// rst clears all counters to their start-of-input values; no clearing pass
// src_stall rises only when the two-entry byte queue is full; the back end waits for
// two free result slots
`default_nettype none
module utf8_decoder_with_position_core
  import u8dp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      src_valid,
  output logic           src_stall,
  input  wire src_item_t src_data,
  output logic           res_valid,
  input  wire logic      res_stall,
  output res_item_t      res_data
);

  logic      item_valid;
  cls_item_t item;
  logic      item_take;
  logic      space_ok;
  oq_push_t  push;

  u8dp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .src_valid  (src_valid),
    .src_stall  (src_stall),
    .src_data   (src_data),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  u8dp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .space_ok   (space_ok),
    .push       (push)
  );

  u8dp_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .space_ok  (space_ok),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

endmodule
`default_nettype wire
